### rtl/two_pole_two_zero_compensator_defines.svh
// ----------------------------------------------------------------------------
// Two-pole two-zero compensator: assertion macros
// Shared property macros for the compensator's concurrent checks.
// ----------------------------------------------------------------------------
`ifndef TWO_POLE_TWO_ZERO_COMPENSATOR_DEFINES_SVH
`define TWO_POLE_TWO_ZERO_COMPENSATOR_DEFINES_SVH

// Same-cycle implication, sampled on clk and off during rst.
`define TPPZ_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk and off during rst.
`define TPPZ_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

### rtl/tppz_pkg.sv
// ----------------------------------------------------------------------------
// Two-pole two-zero compensator package
// Widths, configuration record, register indexes and shared types.
// ----------------------------------------------------------------------------
`default_nettype none

package tppz_pkg;

  // Fixed-point setup.
  localparam int SAMPLE_BITS    = 12;
  localparam int COEF_FRAC_BITS = 24;
  localparam int COEF_W         = 32;
  localparam int DRIVE_W        = 12;

  // Error is level minus sample, one sign bit above the wider operand.
  localparam int ERR_W  = ((SAMPLE_BITS > DRIVE_W) ? SAMPLE_BITS : DRIVE_W) + 1;
  // Output history is non-negative: integer drive bits plus fraction bits.
  localparam int Y_W    = DRIVE_W + COEF_FRAC_BITS;
  // One error product and the sum of the three error products.
  localparam int BP_W   = COEF_W + ERR_W;
  localparam int BS_W   = BP_W + 2;
  // Feedback partial products: coefficient times integer part / fraction part.
  localparam int PH_W   = COEF_W + DRIVE_W + 1;
  localparam int PL_W   = COEF_W + COEF_FRAC_BITS + 1;
  // Accumulator holds five terms of either kind.
  localparam int ACC_W  = COEF_W + ((ERR_W > DRIVE_W) ? ERR_W : (DRIVE_W + 1)) + 3;

  // Queue between the front and back parts.
  localparam int Q_DEPTH = 4;
  localparam int Q_PTR_W = $clog2(Q_DEPTH);
  localparam int Q_CNT_W = $clog2(Q_DEPTH + 1);

  // Configuration port.
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = COEF_W;

  localparam logic [DRIVE_W-1:0] DRIVE_MAX = {DRIVE_W{1'b1}};
  localparam logic [DRIVE_W-1:0] REF_RESET = DRIVE_W'(2048);

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_B0    = 3'd0,
    REG_B1    = 3'd1,
    REG_B2    = 3'd2,
    REG_A1    = 3'd3,
    REG_A2    = 3'd4,
    REG_LOWER = 3'd5,
    REG_UPPER = 3'd6,
    REG_REF   = 3'd7
  } cfg_idx_t;

  typedef struct packed {
    logic signed [COEF_W-1:0] b0_coef;
    logic signed [COEF_W-1:0] b1_coef;
    logic signed [COEF_W-1:0] b2_coef;
    logic signed [COEF_W-1:0] a1_coef;
    logic signed [COEF_W-1:0] a2_coef;
    logic [DRIVE_W-1:0]       lower_clamp;
    logic [DRIVE_W-1:0]       upper_clamp;
    logic [DRIVE_W-1:0]       ref_level;
  } cfg_t;

  typedef logic signed [BS_W-1:0] bsum_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_status_t;

endpackage

`default_nettype wire

### rtl/tppz_front.sv
// ----------------------------------------------------------------------------
// Compensator front part
// Accepts samples, forms the error and the feed-forward sum of error terms.
// ----------------------------------------------------------------------------
`default_nettype none

module tppz_front
  import tppz_pkg::*;
(
  input  wire logic                   clk,
  input  wire logic                   rst,
  input  wire cfg_t                   cfg,
  input  wire logic                   in_valid,
  output logic                        in_stall,
  input  wire logic [SAMPLE_BITS-1:0] sample,
  input  wire q_status_t              q_stat,
  output logic                        push,
  output bsum_t                       push_data
);

  logic                    adv;
  logic                    accept;
  logic signed [ERR_W-1:0] e0;

  // Error history, updated as each item is accepted.
  logic signed [ERR_W-1:0] e1_hist;
  logic signed [ERR_W-1:0] e2_hist;

  // Stage one: the three errors of the item.
  logic                    s1_valid;
  logic signed [ERR_W-1:0] s1_e0;
  logic signed [ERR_W-1:0] s1_e1;
  logic signed [ERR_W-1:0] s1_e2;

  // Stage two: the three error products.
  logic                   s2_valid;
  logic signed [BP_W-1:0] s2_p0;
  logic signed [BP_W-1:0] s2_p1;
  logic signed [BP_W-1:0] s2_p2;

  // The whole pipeline holds while the queue is full.
  assign adv      = !q_stat.full;
  assign in_stall = q_stat.full;
  assign accept   = in_valid && adv;

  // Error is the wrapped difference; its sign bit is correct at ERR_W bits.
  assign e0 = ERR_W'(cfg.ref_level) - ERR_W'(sample);

  // Control and history registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
      s2_valid <= 1'b0;
      e1_hist  <= '0;
      e2_hist  <= '0;
    end else if (adv) begin
      s1_valid <= accept;
      s2_valid <= s1_valid;
      if (accept) begin
        e1_hist <= e0;
        e2_hist <= e1_hist;
      end
    end
  end

  // Payload registers of both stages.
  always_ff @(posedge clk) begin
    if (adv) begin
      if (accept) begin
        s1_e0 <= e0;
        s1_e1 <= e1_hist;
        s1_e2 <= e2_hist;
      end
      s2_p0 <= cfg.b0_coef * s1_e0;
      s2_p1 <= cfg.b1_coef * s1_e1;
      s2_p2 <= cfg.b2_coef * s1_e2;
    end
  end

  // Sum the error products on the way into the queue.
  assign push      = s2_valid && adv;
  assign push_data = BS_W'(s2_p0) + BS_W'(s2_p1) + BS_W'(s2_p2);

endmodule

`default_nettype wire

### rtl/tppz_queue.sv
// ----------------------------------------------------------------------------
// Compensator item queue
// Short register queue that decouples the front and back parts.
// ----------------------------------------------------------------------------
`default_nettype none

module tppz_queue
  import tppz_pkg::*;
(
  input  wire logic  clk,
  input  wire logic  rst,
  input  wire logic  push,
  input  wire bsum_t push_data,
  input  wire logic  pop,
  output bsum_t      pop_data,
  output q_status_t  q_stat
);

  bsum_t              entry [Q_DEPTH];
  logic [Q_PTR_W-1:0] wr_ptr;
  logic [Q_PTR_W-1:0] rd_ptr;
  logic [Q_CNT_W-1:0] count;

  // Pointers and fill count.
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

  // Storage.
  always_ff @(posedge clk) begin
    if (push) begin
      entry[wr_ptr] <= push_data;
    end
  end

  assign pop_data     = entry[rd_ptr];
  assign q_stat.full  = (count == Q_CNT_W'(Q_DEPTH));
  assign q_stat.empty = (count == '0);

endmodule

`default_nettype wire

### rtl/tppz_back.sv
// ----------------------------------------------------------------------------
// Compensator back part
// Adds the output feedback terms, clamps, keeps output history and drives.
// ----------------------------------------------------------------------------
`default_nettype none

module tppz_back
  import tppz_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire cfg_t        cfg,
  input  wire q_status_t   q_stat,
  input  wire bsum_t       pop_data,
  output logic             pop,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic [DRIVE_W-1:0] drive
);

  typedef enum logic [1:0] {
    ST_MUL = 2'b01,
    ST_SUM = 2'b10
  } back_state_t;

  back_state_t state;
  back_state_t state_next;

  // Output history: clamped results, never negative.
  logic [Y_W-1:0] y1;
  logic [Y_W-1:0] y2;

  // Registered operands of the sum step.
  bsum_t                  bsum;
  logic signed [PH_W-1:0] ph1;
  logic signed [PL_W-1:0] pl1;
  logic signed [PH_W-1:0] ph2;
  logic signed [PL_W-1:0] pl2;

  logic                    slot_free;
  logic                    finish;
  logic signed [ACC_W-1:0] acc;
  logic signed [ACC_W-1:0] hi_lim;
  logic signed [ACC_W-1:0] lo_lim;
  logic signed [ACC_W-1:0] acc_cl;

  assign slot_free = !out_valid || !out_stall;
  assign pop       = (state == ST_MUL) && !q_stat.empty;
  assign finish    = (state == ST_SUM) && slot_free;

  // Two-step loop: multiply by the history, then sum and clamp.
  always_comb begin
    state_next = state;
    case (state)
      ST_MUL: begin
        if (pop) begin
          state_next = ST_SUM;
        end
      end
      ST_SUM: begin
        if (finish) begin
          state_next = ST_MUL;
        end
      end
      default: state_next = ST_MUL;
    endcase
  end

  // Sum of feed-forward and floored feedback terms, then clamp.
  always_comb begin
    hi_lim = $signed(ACC_W'({cfg.upper_clamp, {COEF_FRAC_BITS{1'b0}}}));
    lo_lim = $signed(ACC_W'({cfg.lower_clamp, {COEF_FRAC_BITS{1'b0}}}));
    acc    = ACC_W'(bsum) + ACC_W'(ph1) + ACC_W'(pl1 >>> COEF_FRAC_BITS)
           + ACC_W'(ph2) + ACC_W'(pl2 >>> COEF_FRAC_BITS);
    acc_cl = acc;
    if (acc_cl >= hi_lim) begin
      acc_cl = hi_lim;
    end
    if (acc_cl < lo_lim) begin
      acc_cl = lo_lim;
    end
  end

  // Control state, output valid and history.
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_MUL;
      out_valid <= 1'b0;
      y1        <= '0;
      y2        <= '0;
    end else begin
      state <= state_next;
      if (finish) begin
        out_valid <= 1'b1;
        y1        <= acc_cl[Y_W-1:0];
        y2        <= y1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Partial products of the feedback terms, and the drive value.
  always_ff @(posedge clk) begin
    if (pop) begin
      bsum <= pop_data;
      ph1  <= cfg.a1_coef * $signed({1'b0, y1[Y_W-1 -: DRIVE_W]});
      pl1  <= cfg.a1_coef * $signed({1'b0, y1[COEF_FRAC_BITS-1:0]});
      ph2  <= cfg.a2_coef * $signed({1'b0, y2[Y_W-1 -: DRIVE_W]});
      pl2  <= cfg.a2_coef * $signed({1'b0, y2[COEF_FRAC_BITS-1:0]});
    end
    if (finish) begin
      drive <= acc_cl[COEF_FRAC_BITS +: DRIVE_W];
    end
  end

endmodule

`default_nettype wire

### rtl/two_pole_two_zero_compensator.sv
// An accepted sample passes the stage-one error registers, the stage-two product
// registers, the queue, the back part's partial-product registers and the drive
// register. The output history feedback loop takes a new item only once the last
// is through its history multiplies and its sum and clamp, which waits on out_stall.
// The input side takes items every cycle until the four-entry queue is full.
// Reset (rst, synchronous, active high) clears the histories, the queue and the
// coefficients, and sets the clamps to 0 and 4095 and the level to 2048.
// ----------------------------------------------------------------------------
// Two-pole two-zero compensator
// Fixed-point control-loop filter with clamped output and anti-windup.
// ----------------------------------------------------------------------------
`default_nettype none

`include "two_pole_two_zero_compensator_defines.svh"

module two_pole_two_zero_compensator
  import tppz_pkg::*;
(
  input  wire logic                   clk,
  input  wire logic                   rst,
  input  wire logic                   cfg_we,
  input  wire logic [CFG_IDX_W-1:0]   cfg_index,
  input  wire logic [CFG_DATA_W-1:0]  cfg_data,
  input  wire logic                   in_valid,
  output logic                        in_stall,
  input  wire logic [SAMPLE_BITS-1:0] sample,
  output logic                        out_valid,
  input  wire logic                   out_stall,
  output logic [DRIVE_W-1:0]          drive
);

  cfg_t      cfg;
  q_status_t q_stat;
  logic      q_push;
  bsum_t     q_push_data;
  logic      q_pop;
  bsum_t     q_pop_data;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.b0_coef     <= '0;
      cfg.b1_coef     <= '0;
      cfg.b2_coef     <= '0;
      cfg.a1_coef     <= '0;
      cfg.a2_coef     <= '0;
      cfg.lower_clamp <= '0;
      cfg.upper_clamp <= DRIVE_MAX;
      cfg.ref_level   <= REF_RESET;
    end else if (cfg_we) begin
      case (cfg_idx_t'(cfg_index))
        REG_B0:    cfg.b0_coef     <= $signed(cfg_data);
        REG_B1:    cfg.b1_coef     <= $signed(cfg_data);
        REG_B2:    cfg.b2_coef     <= $signed(cfg_data);
        REG_A1:    cfg.a1_coef     <= $signed(cfg_data);
        REG_A2:    cfg.a2_coef     <= $signed(cfg_data);
        REG_LOWER: cfg.lower_clamp <= cfg_data[DRIVE_W-1:0];
        REG_UPPER: cfg.upper_clamp <= cfg_data[DRIVE_W-1:0];
        REG_REF:   cfg.ref_level   <= cfg_data[DRIVE_W-1:0];
        default: ;
      endcase
    end
  end

  tppz_front u_front (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .sample    (sample),
    .q_stat    (q_stat),
    .push      (q_push),
    .push_data (q_push_data)
  );

  tppz_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (q_push),
    .push_data (q_push_data),
    .pop       (q_pop),
    .pop_data  (q_pop_data),
    .q_stat    (q_stat)
  );

  tppz_back u_back (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .q_stat    (q_stat),
    .pop_data  (q_pop_data),
    .pop       (q_pop),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .drive     (drive)
  );

  // The front never writes into a full queue.
  `TPPZ_ASSERT_NOW(a_no_overflow, q_push, !q_stat.full, "queue written while full")

  // The feedback loop never takes two items back to back.
  `TPPZ_ASSERT_NEXT(a_loop_spacing, q_pop, !q_pop, "back part took two items in a row")

  // A presented drive value lies within the clamp window; the lower clamp wins if above the upper.
  `TPPZ_ASSERT_NOW(a_drive_range, out_valid,
    (drive >= cfg.lower_clamp) && ((drive <= cfg.upper_clamp) || (drive == cfg.lower_clamp)),
    "drive value outside the clamp window")

endmodule

`default_nettype wire
